[rtl/ilie_pkg.sv]
// ----------------------------------------------------------------------------
// ilie_pkg
// Shared types and codes for the indexed list with insert and erase.
// ----------------------------------------------------------------------------
package ilie_pkg;

    localparam int ILIE_DEPTH      = 64;
    localparam int ILIE_ELEM_WIDTH = 32;

    // Index width for cell control, wide enough for the largest supported depth
    localparam int CTL_AW = 11;

    localparam int CMD_W  = 3;
    localparam int POS_W  = 7;
    localparam int WORD_W = 32;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RESIZE = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    // Cell operations broadcast along the row
    localparam logic [1:0] OP_NOP    = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_ERASE  = 2'd2;
    localparam logic [1:0] OP_TRIM   = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [CTL_AW-1:0] at;
    } ilie_ctl_t;

endpackage

[rtl/indexed_list_insert_erase.sv]
// ----------------------------------------------------------------------------
// indexed_list_insert_erase
// Ordered list of up to DEPTH signed words with push, pop, insert, erase,
// read, resize and clear.
// ----------------------------------------------------------------------------
// Each list slot is a cell in a row; a command is decoded against the stored
// length and broadcast to all cells, which shift, load or clear together in
// the cycle the item is accepted, so insert and erase cost no more than push.
// The result (read word, length, front, back, empty flag, status) is picked
// from the updated row once the output register can take it, and held there.
// out_valid rises once the item has passed the selection stage and the output
// register; the block sustains one item per cycle as long as out_stall stays
// low, paced by the single result selection stage. Rejected commands leave the
// list unchanged. Reset clears every slot at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module indexed_list_insert_erase #(
    parameter int DEPTH      = ilie_pkg::ILIE_DEPTH,
    parameter int ELEM_WIDTH = ilie_pkg::ILIE_ELEM_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ilie_pkg::CMD_W-1:0]    cmd,
    input  logic [ilie_pkg::POS_W-1:0]    position,
    input  logic signed [ilie_pkg::WORD_W-1:0] value,
    input  logic [ilie_pkg::POS_W-1:0]    new_length,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [ilie_pkg::WORD_W-1:0] read_value,
    output logic [ilie_pkg::POS_W-1:0]    length,
    output logic signed [ilie_pkg::WORD_W-1:0] front_value,
    output logic signed [ilie_pkg::WORD_W-1:0] back_value,
    output logic                          is_empty,
    output logic [ilie_pkg::STAT_W-1:0]   status
);
    import ilie_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CTL_AW-1:0] DEPTH_A = CTL_AW'(DEPTH);

    // list length
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_next;
    logic [CTL_AW-1:0]  cnt_w;

    // result selection stage
    logic               pend_reg;
    logic               pend_next;
    logic [STAT_W-1:0]  st_reg;
    logic [STAT_W-1:0]  st_next;
    logic               rd_ok_reg;
    logic               rd_ok_next;
    logic [POS_W-1:0]   pos_reg;

    // output register
    logic               ov_reg;
    logic               ov_next;
    logic [WORD_W-1:0]  rd_val_reg;
    logic [WORD_W-1:0]  front_reg;
    logic [WORD_W-1:0]  back_reg;
    logic [POS_W-1:0]   len_reg;
    logic               empty_reg;
    logic [STAT_W-1:0]  stat_reg;

    logic               accept;
    logic               load_out;
    ilie_ctl_t          ctl;
    logic [CTL_AW-1:0]  pos_w;
    logic [CTL_AW-1:0]  nlen_w;
    logic [63:0]        value_x;
    logic [ELEM_WIDTH-1:0] load_val;

    logic [ELEM_WIDTH-1:0] cell_q [DEPTH];
    logic [ELEM_WIDTH-1:0] rd_pick;
    logic [ELEM_WIDTH-1:0] back_pick;
    logic [63:0]        rd_x;
    logic [63:0]        front_x;
    logic [63:0]        back_x;
    logic [CTL_AW-1:0]  back_idx;

    assign cnt_w    = CTL_AW'(cnt_reg);
    assign pos_w    = CTL_AW'(position);
    assign nlen_w   = CTL_AW'(new_length);
    assign value_x  = 64'(value);
    assign load_val = value_x[ELEM_WIDTH-1:0];

    assign load_out = pend_reg && (!ov_reg || !out_stall);
    assign in_stall = pend_reg && !load_out;
    assign accept   = in_valid && !in_stall;

    // decode against the current length
    always_comb
    begin
        ctl        = '{op: OP_NOP, at: '0};
        cnt_next   = cnt_reg;
        st_next    = ST_OK;
        rd_ok_next = 1'b0;
        if (accept)
        begin
            case (cmd)
                CMD_PUSH:
                begin
                    if (cnt_w >= DEPTH_A)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        // push is an insert at the end
                        ctl      = '{op: OP_INSERT, at: cnt_w};
                        cnt_next = CW'(cnt_w + CTL_AW'(1));
                    end
                end
                CMD_POP:
                begin
                    if (cnt_w == '0)
                    begin
                        st_next = ST_EMPTY;
                    end
                    else
                    begin
                        ctl      = '{op: OP_TRIM, at: cnt_w - CTL_AW'(1)};
                        cnt_next = CW'(cnt_w - CTL_AW'(1));
                    end
                end
                CMD_INSERT:
                begin
                    if (pos_w > cnt_w)
                    begin
                        st_next = ST_RANGE;
                    end
                    else if (cnt_w >= DEPTH_A)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        ctl      = '{op: OP_INSERT, at: pos_w};
                        cnt_next = CW'(cnt_w + CTL_AW'(1));
                    end
                end
                CMD_ERASE:
                begin
                    if (cnt_w == '0)
                    begin
                        st_next = ST_EMPTY;
                    end
                    else if (pos_w >= cnt_w)
                    begin
                        st_next = ST_RANGE;
                    end
                    else
                    begin
                        ctl      = '{op: OP_ERASE, at: pos_w};
                        cnt_next = CW'(cnt_w - CTL_AW'(1));
                    end
                end
                CMD_READ:
                begin
                    if (cnt_w == '0)
                    begin
                        st_next = ST_EMPTY;
                    end
                    else if (pos_w >= cnt_w)
                    begin
                        st_next = ST_RANGE;
                    end
                    else
                    begin
                        rd_ok_next = 1'b1;
                    end
                end
                CMD_RESIZE:
                begin
                    if (nlen_w > DEPTH_A)
                    begin
                        st_next = ST_RANGE;
                    end
                    else
                    begin
                        ctl      = '{op: OP_TRIM, at: nlen_w};
                        cnt_next = CW'(nlen_w);
                    end
                end
                CMD_CLEAR:
                begin
                    ctl      = '{op: OP_TRIM, at: '0};
                    cnt_next = '0;
                end
                default:
                begin
                    ctl = '{op: OP_NOP, at: '0};
                end
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [ELEM_WIDTH-1:0] left_d;
            logic [ELEM_WIDTH-1:0] right_d;
            if (gi == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_mid_l
                assign left_d = cell_q[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_mid_r
                assign right_d = cell_q[gi+1];
            end
            ilie_cell #(
                .IDX        (gi),
                .ELEM_WIDTH (ELEM_WIDTH)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .load_d  (load_val),
                .left_d  (left_d),
                .right_d (right_d),
                .q       (cell_q[gi])
            );
        end
    endgenerate

    assign back_idx = cnt_w - CTL_AW'(1);

    ilie_pick #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_pick_rd (
        .cells (cell_q),
        .sel   (CTL_AW'(pos_reg)),
        .en    (rd_ok_reg),
        .dout  (rd_pick)
    );

    ilie_pick #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_pick_back (
        .cells (cell_q),
        .sel   (back_idx),
        .en    (cnt_w != '0),
        .dout  (back_pick)
    );

    // sign-extend stored words into the result fields; front slot is zero when empty
    assign rd_x    = 64'(signed'(rd_pick));
    assign front_x = 64'(signed'(cell_q[0]));
    assign back_x  = 64'(signed'(back_pick));

    assign pend_next = accept || (pend_reg && !load_out);
    assign ov_next   = load_out || (ov_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            pend_reg <= pend_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_reg    <= st_next;
            rd_ok_reg <= rd_ok_next;
            pos_reg   <= position;
        end
        if (load_out)
        begin
            rd_val_reg <= rd_x[WORD_W-1:0];
            front_reg  <= front_x[WORD_W-1:0];
            back_reg   <= back_x[WORD_W-1:0];
            len_reg    <= cnt_w[POS_W-1:0];
            empty_reg  <= (cnt_w == '0);
            stat_reg   <= st_reg;
        end
    end

    assign out_valid   = ov_reg;
    assign read_value  = signed'(rd_val_reg);
    assign front_value = signed'(front_reg);
    assign back_value  = signed'(back_reg);
    assign length      = len_reg;
    assign is_empty    = empty_reg;
    assign status      = stat_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_w <= DEPTH_A)
        else $error("list length above capacity");

    a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_w < DEPTH_A) |-> (cell_q[DEPTH-1] == '0))
        else $error("slot beyond the end is not zero");

    a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && (st_reg != ST_OK)) |-> (cnt_reg == $past(cnt_reg)))
        else $error("rejected item changed the length");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(pend_reg))
        else $error("result without a pending item");

endmodule

[rtl/ilie_cell.sv]
// ----------------------------------------------------------------------------
// ilie_cell
// One slot of the list: holds, loads, shifts from a neighbor or clears.
// ----------------------------------------------------------------------------
module ilie_cell #(
    parameter int IDX        = 0,
    parameter int ELEM_WIDTH = ilie_pkg::ILIE_ELEM_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ilie_pkg::ilie_ctl_t    ctl,
    input  logic [ELEM_WIDTH-1:0]  load_d,
    input  logic [ELEM_WIDTH-1:0]  left_d,
    input  logic [ELEM_WIDTH-1:0]  right_d,
    output logic [ELEM_WIDTH-1:0]  q
);
    import ilie_pkg::*;

    localparam logic [CTL_AW-1:0] MY_IDX = CTL_AW'(IDX);

    logic [ELEM_WIDTH-1:0] q_reg;
    logic [ELEM_WIDTH-1:0] q_next;

    always_comb
    begin
        q_next = q_reg;
        case (ctl.op)
            OP_INSERT:
            begin
                if (MY_IDX > ctl.at)
                begin
                    q_next = left_d;
                end
                else if (MY_IDX == ctl.at)
                begin
                    q_next = load_d;
                end
            end
            OP_ERASE:
            begin
                // slots at and above the end are zero, so pulling from the right is safe
                if (MY_IDX >= ctl.at)
                begin
                    q_next = right_d;
                end
            end
            OP_TRIM:
            begin
                if (MY_IDX >= ctl.at)
                begin
                    q_next = '0;
                end
            end
            default:
            begin
                q_next = q_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

[rtl/ilie_pick.sv]
// ----------------------------------------------------------------------------
// ilie_pick
// Select one cell of the row by index, zero when disabled.
// ----------------------------------------------------------------------------
module ilie_pick #(
    parameter int DEPTH      = ilie_pkg::ILIE_DEPTH,
    parameter int ELEM_WIDTH = ilie_pkg::ILIE_ELEM_WIDTH
) (
    input  logic [ELEM_WIDTH-1:0]         cells [DEPTH],
    input  logic [ilie_pkg::CTL_AW-1:0]   sel,
    input  logic                          en,
    output logic [ELEM_WIDTH-1:0]         dout
);
    import ilie_pkg::*;

    always_comb
    begin
        dout = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (en && (sel == CTL_AW'(i)))
            begin
                dout = dout | cells[i];
            end
        end
    end

endmodule
